// ===== rtl/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// nta_pkg: shared types and constants of the neighbour table
// Request and response payloads, command and register codes, and the
// classified operation passed from the front end to the table engine.
// ----------------------------------------------------------------------------
package nta_pkg;

   // Default sizing of the table.
   localparam int ENTRIES_DEFAULT   = 8;
   localparam int ADDR_BITS_DEFAULT = 16;

   // Reset values of the configuration registers.
   localparam logic signed [7:0] WORST_SIGNAL_RESET = -8'sd70;
   localparam logic        [7:0] EVICT_AGE_RESET    = 8'd4;

   // Width of the address field on the request port.
   localparam int REQ_ADDR_BITS = 16;

   // Depth of the operation queue between front end and engine.
   localparam int OPQ_DEPTH = 2;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORST_SIGNAL = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EVICT_AGE    = 4'd1;

   // Command codes.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_FIND   = 2'd3;

   localparam logic [7:0] AGE_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0]                 cmd;
      logic [REQ_ADDR_BITS-1:0]   neighbor_addr;
      logic signed [7:0]          signal_in;
      logic [7:0]                 quality_in;
   } req_type;

   typedef struct packed {
      logic                       found;
      logic signed [7:0]          signal_out;
      logic [7:0]                 quality_out;
      logic [7:0]                 age_out;
      logic                       stored;
      logic                       removed;
      logic [3:0]                 evicted_count;
      logic [3:0]                 occupancy;
   } rsp_type;

   // A request after decoding by the front end.
   typedef struct packed {
      logic                       tick;
      logic                       add;
      logic                       remove;
      req_type                    req;
   } op_type;

endpackage

// ===== rtl/nta_ram.sv =====
// ----------------------------------------------------------------------------
// nta_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nta_front.sv =====
// ----------------------------------------------------------------------------
// nta_front: request intake and decode
// Decodes each request and holds it in a short queue for the engine.
// ----------------------------------------------------------------------------
module nta_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  nta_pkg::req_type req_data,
   output logic             op_valid,
   input  logic             op_pop,
   output nta_pkg::op_type  op_data
);

   localparam int PTR_BITS = (nta_pkg::OPQ_DEPTH > 1) ? $clog2(nta_pkg::OPQ_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(nta_pkg::OPQ_DEPTH + 1);

   nta_pkg::op_type       slot_ff [nta_pkg::OPQ_DEPTH];
   nta_pkg::op_type       push_op;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   // Decode the command into operation flags; a find sets none of them.
   always_comb begin
      push_op        = '0;
      push_op.req    = req_data;
      unique case (req_data.cmd)
         nta_pkg::CMD_TICK:   push_op.tick   = 1'b1;
         nta_pkg::CMD_ADD:    push_op.add    = 1'b1;
         nta_pkg::CMD_REMOVE: push_op.remove = 1'b1;
         nta_pkg::CMD_FIND:   push_op.tick   = 1'b0;
      endcase
   end

   assign req_full = (count_ff == CNT_BITS'(nta_pkg::OPQ_DEPTH));
   assign op_valid = (count_ff != '0);
   assign op_data  = slot_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(nta_pkg::OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(nta_pkg::OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/nta_back.sv =====
// ----------------------------------------------------------------------------
// nta_back: table engine
// Scans the entry RAM one entry per cycle for each operation, commits the
// update and holds the response until it is taken.
// ----------------------------------------------------------------------------
module nta_back #(
   parameter int ENTRIES   = nta_pkg::ENTRIES_DEFAULT,
   parameter int ADDR_BITS = nta_pkg::ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_pop,
   input  nta_pkg::op_type   op_data,
   input  logic signed [7:0] worst_signal,
   input  logic [7:0]        evict_age,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output nta_pkg::rsp_type  rsp_data
);

   localparam int KEY_BITS  = (ADDR_BITS < nta_pkg::REQ_ADDR_BITS) ? ADDR_BITS
                                                                   : nta_pkg::REQ_ADDR_BITS;
   localparam int WORD_BITS = KEY_BITS + 24;
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   nta_pkg::op_type         op_ff, op_in;
   logic [CNT_BITS-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                    p_vld_ff, p_vld_in;
   logic [IDX_BITS-1:0]     p_idx_ff, p_idx_in;
   logic                    p_ev_ff, p_ev_in;
   logic                    match_ff, match_in;
   logic [IDX_BITS-1:0]     m_idx_ff, m_idx_in;
   logic signed [7:0]       m_sig_ff, m_sig_in;
   logic [7:0]              m_q_ff, m_q_in;
   logic [7:0]              m_age_ff, m_age_in;
   logic                    free_ff, free_in;
   logic [IDX_BITS-1:0]     free_idx_ff, free_idx_in;
   logic [CNT_BITS-1:0]     evict_cnt_ff, evict_cnt_in;
   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [CNT_BITS-1:0]     occ_ff, occ_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   nta_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    ram_rd_en, ram_wr_en;
   logic [IDX_BITS-1:0]     ram_rd_addr, ram_wr_addr;
   logic [WORD_BITS-1:0]    ram_wr_data, ram_rd_data;

   logic [KEY_BITS-1:0]     op_key;
   logic [KEY_BITS-1:0]     e_key;
   logic signed [7:0]       e_sig;
   logic [7:0]              e_q, e_age, e_age_inc;
   logic                    out_free;

   assign op_key    = op_ff.req.neighbor_addr[KEY_BITS-1:0];
   assign e_key     = ram_rd_data[WORD_BITS-1 -: KEY_BITS];
   assign e_sig     = ram_rd_data[23:16];
   assign e_q       = ram_rd_data[15:8];
   assign e_age     = ram_rd_data[7:0];
   assign e_age_inc = (e_age == nta_pkg::AGE_MAX) ? nta_pkg::AGE_MAX : e_age + 8'd1;
   assign out_free  = !rsp_vld_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rd_cnt_in    = rd_cnt_ff;
      p_vld_in     = 1'b0;
      p_idx_in     = p_idx_ff;
      p_ev_in      = p_ev_ff;
      match_in     = match_ff;
      m_idx_in     = m_idx_ff;
      m_sig_in     = m_sig_ff;
      m_q_in       = m_q_ff;
      m_age_in     = m_age_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      evict_cnt_in = evict_cnt_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      op_pop       = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_cnt_ff[IDX_BITS-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = p_idx_ff;
      ram_wr_data  = {e_key, e_sig, e_q, e_age_inc};

      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_pop       = 1'b1;
               op_in        = op_data;
               rd_cnt_in    = '0;
               match_in     = 1'b0;
               free_in      = 1'b0;
               evict_cnt_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue stage: read the next entry.
            if (rd_cnt_ff != CNT_BITS'(ENTRIES)) begin
               ram_rd_en = 1'b1;
               p_vld_in  = 1'b1;
               p_idx_in  = rd_cnt_ff[IDX_BITS-1:0];
               p_ev_in   = valid_ff[rd_cnt_ff[IDX_BITS-1:0]];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end else begin
               state_in = ST_COMMIT;
            end
            // Process stage: the entry read in the previous cycle.
            if (p_vld_ff) begin
               if (op_ff.tick) begin
                  if (p_ev_ff) begin
                     if (e_age_inc >= evict_age) begin
                        valid_in[p_idx_ff] = 1'b0;
                        occ_in             = occ_ff - 1'b1;
                        evict_cnt_in       = evict_cnt_ff + 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                     end
                  end
               end else begin
                  if (p_ev_ff && !match_ff && (e_key == op_key)) begin
                     match_in = 1'b1;
                     m_idx_in = p_idx_ff;
                     m_sig_in = e_sig;
                     m_q_in   = e_q;
                     m_age_in = e_age;
                  end
                  if (!p_ev_ff && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = p_idx_ff;
                  end
               end
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               rsp_in               = '0;
               rsp_in.found         = match_ff;
               rsp_in.signal_out    = match_ff ? m_sig_ff : 8'sd0;
               rsp_in.quality_out   = match_ff ? m_q_ff : 8'd0;
               rsp_in.age_out       = match_ff ? m_age_ff : 8'd0;
               ram_wr_data          = {op_key, op_ff.req.signal_in, op_ff.req.quality_in, 8'd0};
               if (op_ff.tick) begin
                  rsp_in.evicted_count = 4'(evict_cnt_ff);
               end else if (op_ff.add) begin
                  if (match_ff) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = m_idx_ff;
                     rsp_in.stored = 1'b1;
                  end else if (free_ff && (op_ff.req.signal_in > worst_signal)) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     occ_in                = occ_ff + 1'b1;
                     rsp_in.stored         = 1'b1;
                  end
               end else if (op_ff.remove) begin
                  if (match_ff && (m_sig_ff < worst_signal)) begin
                     valid_in[m_idx_ff] = 1'b0;
                     occ_in             = occ_ff - 1'b1;
                     rsp_in.removed     = 1'b1;
                  end
               end
               rsp_in.occupancy = 4'(occ_in);
               rsp_vld_in       = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         p_vld_ff     <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         evict_cnt_ff <= '0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         p_vld_ff     <= p_vld_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         evict_cnt_ff <= evict_cnt_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      p_idx_ff    <= p_idx_in;
      p_ev_ff     <= p_ev_in;
      m_idx_ff    <= m_idx_in;
      m_sig_ff    <= m_sig_in;
      m_q_ff      <= m_q_in;
      m_age_ff    <= m_age_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   nta_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ENTRIES),
      .AW    (IDX_BITS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_empty = !rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // The occupancy counter always agrees with the valid bits.
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      occ_ff == CNT_BITS'($countones(valid_ff)))
      else $error("occupancy counter out of step with valid bits");

   // A waiting response is never overwritten by the next commit.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_pop) |=> (rsp_vld_ff && $stable(rsp_ff)))
      else $error("pending response lost or changed");

   // The scan counter never runs past the end of the table.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_BITS'(ENTRIES))
      else $error("scan counter beyond table size");

   // A recorded match still refers to a live entry when committed.
   a_match_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && match_ff) |-> valid_ff[m_idx_ff])
      else $error("matched entry not valid at commit");

endmodule

// ===== rtl/neighbor_table_with_aging_unit.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_unit: radio neighbour table with ageing
// Keeps link address, signal, quality and age of up to ENTRIES neighbours.
// ----------------------------------------------------------------------------
// Usage
// Requests enter through a queue-like port: a request is taken at a rising
// edge with req_push high and req_full low. Each request carries a command
// (tick, add or refresh, remove if weak, find), an address, a signal and a
// quality. Every request yields exactly one response, presented in order
// on rsp_data while rsp_empty is low and taken at an edge with rsp_pop high.
// The two configuration registers (worst_signal, evict_age) are written via
// csr_valid/csr_index/csr_wdata; csr_ready is always high, and writes are
// expected only while the block is idle.
// The engine walks the entry RAM one entry per cycle, since that RAM has a
// single read port; a request occupies the engine through its idle, scan
// and commit states. The response is registered in the commit state once
// no earlier response is still waiting.
// A two-deep request queue lets new requests be taken while the engine is
// busy and while a finished response waits. If the receiver stalls, the
// held response blocks only the next commit; scanning continues meanwhile.
// Reset empties the table, both queues and restores the register defaults.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_unit #(
   parameter int ENTRIES   = nta_pkg::ENTRIES_DEFAULT,
   parameter int ADDR_BITS = nta_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  nta_pkg::req_type                    req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output nta_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nta_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [7:0]                          csr_wdata
);

   logic signed [7:0] worst_signal_ff;
   logic [7:0]        evict_age_ff;
   logic              op_valid, op_pop;
   nta_pkg::op_type   op_data;

   // Configuration registers; writes to unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         worst_signal_ff <= nta_pkg::WORST_SIGNAL_RESET;
         evict_age_ff    <= nta_pkg::EVICT_AGE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            nta_pkg::CSR_WORST_SIGNAL: worst_signal_ff <= csr_wdata;
            nta_pkg::CSR_EVICT_AGE:    evict_age_ff    <= csr_wdata;
            default: begin
               worst_signal_ff <= worst_signal_ff;
            end
         endcase
      end
   end

   // Front end: decodes each request and queues it for the engine.
   nta_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .op_data  (op_data)
   );

   // Engine: scans the table, applies the update and holds the response.
   nta_back #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (op_valid),
      .op_pop       (op_pop),
      .op_data      (op_data),
      .worst_signal (worst_signal_ff),
      .evict_age    (evict_age_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule
